/* rtl/yuvrot_pkg.sv */
`timescale 1ns / 1ps

package yuvrot_pkg;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rotation_t;

  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_CB   = 2'd1;
  localparam logic [1:0] PLANE_CR   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;

  localparam logic [7:0] SIZE_RESET = 8'd128;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_in;
  } request_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [1:0] plane;
    logic       frame_last;
  } result_t;

  typedef struct packed {
    logic [1:0] plane;
    logic       frame_last;
  } tag_t;

endpackage

/* rtl/yuvrot_store.sv */
`timescale 1ns / 1ps

module yuvrot_store #(
  parameter int DEPTH = 24576,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/yuvrot_cursor.sv */
`timescale 1ns / 1ps

module yuvrot_cursor #(
  parameter int DW = 8,
  parameter int FW = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  yuvrot_pkg::rotation_t rotation,
  input  logic [DW-1:0]         w,
  input  logic [DW-1:0]         h,
  input  logic [FW-1:0]         luma,
  output logic [DW-1:0]         sr,
  output logic [DW-1:0]         sc,
  output logic [DW-1:0]         pw,
  output logic [FW-1:0]         base,
  output yuvrot_pkg::tag_t      tag
);

  import yuvrot_pkg::*;

  logic [DW-1:0] out_column;
  logic [DW-1:0] out_row;
  logic [1:0]    out_plane;

  logic [1:0]    pe;
  logic [DW-1:0] x, y, cur_pw, cur_ph, ow, oh;
  logic [DW-1:0] cur_sr, cur_sc;
  logic [FW-1:0] cur_base;
  logic [DW-1:0] out_column_next, out_row_next;
  logic [1:0]    out_plane_next;
  logic          last_next;

  always_comb begin
    pe = out_plane;
    x  = out_column;
    y  = out_row;
    if (out_plane > PLANE_CR) begin
      pe = PLANE_LUMA;
      x  = '0;
      y  = '0;
    end
    if (pe == PLANE_LUMA) begin
      cur_pw   = w;
      cur_ph   = h;
      cur_base = '0;
    end else begin
      cur_pw   = w >> 1;
      cur_ph   = h >> 1;
      cur_base = (pe == PLANE_CB) ? luma : luma + (luma >> 2);
    end
    if (rotation == ROT_90 || rotation == ROT_270) begin
      ow = cur_ph;
      oh = cur_pw;
    end else begin
      ow = cur_pw;
      oh = cur_ph;
    end
    if (x >= ow || y >= oh) begin
      x = '0;
      y = '0;
    end
    unique case (rotation)
      ROT_90: begin
        cur_sr = cur_ph - DW'(1) - x;
        cur_sc = y;
      end
      ROT_180: begin
        cur_sr = cur_ph - DW'(1) - y;
        cur_sc = cur_pw - DW'(1) - x;
      end
      ROT_270: begin
        cur_sr = x;
        cur_sc = cur_pw - DW'(1) - y;
      end
      default: begin
        cur_sr = y;
        cur_sc = x;
      end
    endcase

    out_column_next = x + DW'(1);
    out_row_next    = y;
    out_plane_next  = pe;
    last_next       = 1'b0;
    if (out_column_next >= ow) begin
      out_column_next = '0;
      out_row_next    = y + DW'(1);
      if (out_row_next >= oh) begin
        out_row_next = '0;
        if (pe == PLANE_CR) begin
          out_plane_next = PLANE_LUMA;
          last_next      = 1'b1;
        end else begin
          out_plane_next = pe + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column <= '0;
      out_row    <= '0;
      out_plane  <= PLANE_LUMA;
    end else if (advance) begin
      out_column <= out_column_next;
      out_row    <= out_row_next;
      out_plane  <= out_plane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sr             <= cur_sr;
      sc             <= cur_sc;
      pw             <= cur_pw;
      base           <= cur_base;
      tag.plane      <= pe;
      tag.frame_last <= last_next;
    end
  end

endmodule

/* rtl/planar_yuv420_frame_rotator.sv */
`timescale 1ns / 1ps
// Loads can be accepted in every cycle while busy is low.
// A read request is accepted in S_IDLE and then passes S_MUL, S_ADDR and S_DATA; its result
// strobes on done in S_DATA, and the next request is taken only once the state is back in S_IDLE.
// These states hold the address multiply and the registered read of the single-port frame store.
// Reset and every register write hold busy high while a settle counter runs down; the store is not cleared.

module planar_yuv420_frame_rotator #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  yuvrot_pkg::request_t request,
  output logic                 done,
  output yuvrot_pkg::result_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import yuvrot_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
  localparam int AW      = $clog2(DEPTH);
  localparam int FW      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_DATA
  } state_t;

  state_t        state;
  rotation_t     rotation;
  logic [7:0]    source_width;
  logic [7:0]    source_height;
  logic [1:0]    settle;
  logic [DW-1:0] w, h;
  logic [FW-1:0] luma, frame;
  logic [AW-1:0] load_position;
  logic [FW-1:0] load_inc;
  logic [2*DW-1:0] prod;

  logic          cfg_write, accept, do_load, do_read, mem_re;
  logic [AW-1:0] rd_addr, mem_addr;
  logic [FW:0]   rd_sum;
  logic [DW-1:0] sr, sc, pw;
  logic [FW-1:0] base;
  logic [7:0]    rdata;
  tag_t          tag;

  function automatic logic [DW-1:0] eff_size(input logic [7:0] v, input int maxv);
    logic [DW-1:0] r;
    if (32'(v) < 2) begin
      r = DW'(2);
    end else if (32'(v) > maxv) begin
      r = DW'(maxv);
    end else begin
      r = DW'(v);
    end
    return r & ~DW'(1);
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign busy      = (state != S_IDLE) || (settle != 2'd0);
  assign accept    = start & ~busy;
  assign do_load   = accept & (request.opcode == OP_LOAD);
  assign do_read   = accept & (request.opcode == OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation      <= ROT_0;
      source_width  <= SIZE_RESET;
      source_height <= SIZE_RESET;
      settle        <= 2'd3;
    end else begin
      if (cfg_write) begin
        settle <= 2'd3;
        unique case (paddr[3:2])
          REG_ROTATION: rotation      <= rotation_t'(pwdata[1:0]);
          REG_WIDTH:    source_width  <= pwdata[7:0];
          REG_HEIGHT:   source_height <= pwdata[7:0];
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROTATION: prdata = {30'd0, rotation};
      REG_WIDTH:    prdata = {24'd0, source_width};
      REG_HEIGHT:   prdata = {24'd0, source_height};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    w     <= eff_size(source_width, MAX_WIDTH);
    h     <= eff_size(source_height, MAX_HEIGHT);
    luma  <= FW'(w * h);
    frame <= luma + (luma >> 1);
  end

  assign load_inc = FW'(load_position) + FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (do_load) begin
      load_position <= (load_inc >= frame) ? '0 : AW'(load_inc);
    end
  end

  yuvrot_cursor #(
    .DW(DW),
    .FW(FW)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .advance  (do_read),
    .rotation (rotation),
    .w        (w),
    .h        (h),
    .luma     (luma),
    .sr       (sr),
    .sc       (sc),
    .pw       (pw),
    .base     (base),
    .tag      (tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (do_read) state <= S_MUL;
        S_MUL: begin
          prod  <= sr * pw;
          state <= S_ADDR;
        end
        S_ADDR: state <= S_DATA;
        S_DATA: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rd_sum   = (FW + 1)'(base) + (FW + 1)'(prod) + (FW + 1)'(sc);
  assign rd_addr  = rd_sum[AW-1:0];
  assign mem_re   = (state == S_ADDR);
  assign mem_addr = do_load ? load_position : rd_addr;

  yuvrot_store #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (do_load),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (request.pixel_in),
    .rdata (rdata)
  );

  assign done              = (state == S_DATA);
  assign result.pixel_out  = rdata;
  assign result.plane      = tag.plane;
  assign result.frame_last = tag.frame_last;

endmodule
